FILE: hdl/iir_pkg.sv
// Shared constants, types and helper functions of the integer IIR filter.
package iir_pkg;

    localparam int MAX_TAPS     = 8;
    localparam int SAMPLE_WIDTH = 16;
    localparam int COEF_W       = 16;
    localparam int CFG_W        = 64;
    localparam int CFG_IDX_W    = 3;
    localparam int TAPREG_W     = 4;
    localparam int COEF_IDX_W   = 3;

    localparam int HIST_DEPTH   = MAX_TAPS - 1;
    localparam int HIDX_W       = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;
    localparam int TAP_W        = $clog2(MAX_TAPS);
    localparam int CNT_W        = $clog2(MAX_TAPS + 1);
    localparam int PROD_W       = COEF_W + SAMPLE_WIDTH;
    localparam int ACC_W        = PROD_W + $clog2(2 * MAX_TAPS);
    localparam int DIVCNT_W     = $clog2(ACC_W + 1);
    localparam int COEF_PER_REG = CFG_W / COEF_W;

    localparam logic [ACC_W-1:0] Q_POS_LIMIT = ACC_W'((2 ** (SAMPLE_WIDTH - 1)) - 1);
    localparam logic [ACC_W-1:0] Q_NEG_LIMIT = ACC_W'(2 ** (SAMPLE_WIDTH - 1));

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FF_LO,
        CFG_FF_HI,
        CFG_FB_LO,
        CFG_FB_HI,
        CFG_FF_TAPS,
        CFG_FB_TAPS
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FF,
        ST_FB,
        ST_DRAIN,
        ST_ROUND,
        ST_DSET,
        ST_DIV,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic              start;
        logic [ACC_W-1:0]  dividend;
        logic [COEF_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [ACC_W-1:0] quotient;
    } t_div_rsp;

    // Pick coefficient k out of the low/high register pair.
    function automatic logic signed [COEF_W-1:0] coef_at(
        input logic [CFG_W-1:0]      lo,
        input logic [CFG_W-1:0]      hi,
        input logic [COEF_IDX_W-1:0] k
    );
        logic [CFG_W-1:0] word;
        word = k[COEF_IDX_W-1] ? hi : lo;
        return word[k[COEF_IDX_W-2:0] * COEF_W +: COEF_W];
    endfunction

    // Limit a configured tap count to the number of taps built.
    function automatic logic [CNT_W-1:0] clamp_taps(input logic [TAPREG_W-1:0] t);
        if (t > TAPREG_W'(MAX_TAPS)) begin
            return CNT_W'(MAX_TAPS);
        end
        return t[CNT_W-1:0];
    endfunction

endpackage

FILE: hdl/integer_iir_filter_top.sv
// Top level of the direct-form I integer IIR filter with its sequencer and MAC datapath.
//
// Each accepted item (a 16-bit signed sample and a first flag) yields one result
// item: y[n] = round(sum(b[j]*x[n-j]) - sum(a[j]*y[n-j], j>=1)) / a0, where
// a0/2 is added before a division that truncates toward zero, and the quotient is
// saturated to 16 bits (clipped flag). A zero a0 gives 0 with divide_error set.
// A high first flag clears both histories before the sample is used. The block
// handles one item at a time: o_in_stall is high from the cycle after an item is
// accepted until its result has been loaded into the output register. One shared
// 16x16 multiplier runs one tap per cycle, then a bit-serial divider produces one
// quotient bit per cycle. A finished result waits in the sequencer while the
// output register is still held by a stall. The next item may be accepted while
// the previous result still waits in the output register. Configuration is taken on
// any cycle (o_cfg_ready is tied high); write it only while the block is idle.
// Writes to register indexes beyond the six defined are ignored.
module integer_iir_filter_top import iir_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input item channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic signed [15:0]    i_sample,
    input  logic                  i_first,
    // result item channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic signed [15:0]    o_filtered,
    output logic                  o_clipped,
    output logic                  o_divide_error,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    // ---------------------------------------------------------------- config
    logic [CFG_W-1:0]    r_ff_lo, r_ff_hi, r_fb_lo, r_fb_hi;
    logic [TAPREG_W-1:0] r_ff_taps, r_fb_taps;
    logic                cfg_wr;

    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ff_lo   <= CFG_W'(1);
            r_ff_hi   <= '0;
            r_fb_lo   <= CFG_W'(1);
            r_fb_hi   <= '0;
            r_ff_taps <= TAPREG_W'(1);
            r_fb_taps <= TAPREG_W'(1);
        end else if (cfg_wr) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_FF_LO:   r_ff_lo   <= i_cfg_data;
                CFG_FF_HI:   r_ff_hi   <= i_cfg_data;
                CFG_FB_LO:   r_fb_lo   <= i_cfg_data;
                CFG_FB_HI:   r_fb_hi   <= i_cfg_data;
                CFG_FF_TAPS: r_ff_taps <= i_cfg_data[TAPREG_W-1:0];
                CFG_FB_TAPS: r_fb_taps <= i_cfg_data[TAPREG_W-1:0];
                default: begin
                    // undefined index: drop the write
                end
            endcase
        end
    end

    // Derived configuration values
    logic [CNT_W-1:0]         nb, na;
    logic signed [COEF_W-1:0] a0;
    logic [COEF_W-1:0]        a0_mag;
    logic                     a0_zero;
    logic [ACC_W-1:0]         half_mag;
    logic [ACC_W-1:0]         half;

    assign nb       = clamp_taps(r_ff_taps);
    assign na       = clamp_taps(r_fb_taps);
    assign a0       = coef_at(r_fb_lo, r_fb_hi, COEF_IDX_W'(0));
    assign a0_mag   = a0[COEF_W-1] ? COEF_W'(-a0) : COEF_W'(a0);
    assign a0_zero  = (a0 == '0);
    // a0/2 truncated toward zero keeps the sign of a0
    assign half_mag = ACC_W'(a0_mag >> 1);
    assign half     = a0[COEF_W-1] ? (~half_mag + ACC_W'(1)) : half_mag;

    // ---------------------------------------------------------------- handshakes
    t_state r_state, n_state;
    logic   r_out_vld;
    logic   in_acc, out_acc, out_free;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign out_acc     = r_out_vld && !i_out_stall;
    assign out_free    = !r_out_vld || !i_out_stall;

    // ---------------------------------------------------------------- sequencer
    logic [TAP_W-1:0] r_tap, n_tap;
    logic [CNT_W-1:0] tap_inc;
    logic             tap_last_ff, tap_last_fb;
    logic             issue, issue_sub, div_start, fin_go;
    t_div_req         div_req;
    t_div_rsp         div_rsp;

    assign tap_inc     = CNT_W'(r_tap) + CNT_W'(1);
    assign tap_last_ff = (tap_inc == nb);
    assign tap_last_fb = (tap_inc == na);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (nb != '0) begin
                        n_state = ST_FF;
                    end else if (na > CNT_W'(1)) begin
                        n_state = ST_FB;
                    end else begin
                        n_state = ST_DRAIN;
                    end
                end
            end
            ST_FF: begin
                if (tap_last_ff) begin
                    n_state = (na > CNT_W'(1)) ? ST_FB : ST_DRAIN;
                end
            end
            ST_FB: begin
                if (tap_last_fb) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: n_state = ST_ROUND;
            ST_ROUND: n_state = ST_DSET;
            ST_DSET:  n_state = a0_zero ? ST_FIN : ST_DIV;
            ST_DIV: begin
                if (div_rsp.done) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        issue     = 1'b0;
        issue_sub = 1'b0;
        div_start = 1'b0;
        fin_go    = 1'b0;
        n_tap     = r_tap;
        unique case (r_state)
            ST_IDLE: begin
                // feedback taps start at a1
                if (in_acc) begin
                    n_tap = (nb != '0) ? TAP_W'(0) : TAP_W'(1);
                end
            end
            ST_FF: begin
                issue = 1'b1;
                n_tap = tap_last_ff ? TAP_W'(1) : (r_tap + TAP_W'(1));
            end
            ST_FB: begin
                issue     = 1'b1;
                issue_sub = 1'b1;
                n_tap     = r_tap + TAP_W'(1);
            end
            ST_DSET: div_start = !a0_zero;
            ST_FIN:  fin_go    = out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_tap   <= '0;
        end else begin
            r_state <= n_state;
            r_tap   <= n_tap;
        end
    end

    // ---------------------------------------------------------------- histories
    logic signed [SAMPLE_WIDTH-1:0] r_x;
    logic signed [SAMPLE_WIDTH-1:0] r_xh [HIST_DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] r_yh [HIST_DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] fin_y;
    logic                           fin_clip;
    logic [TAP_W-1:0]               tap_m1;
    logic [HIDX_W-1:0]              hidx;

    assign tap_m1 = r_tap - TAP_W'(1);
    assign hidx   = tap_m1[HIDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x <= i_sample[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < HIST_DEPTH; k++) begin
                r_xh[k] <= '0;
                r_yh[k] <= '0;
            end
        end else if (in_acc && i_first) begin
            // a new sequence sees zeros before its first sample
            for (int k = 0; k < HIST_DEPTH; k++) begin
                r_xh[k] <= '0;
                r_yh[k] <= '0;
            end
        end else if (fin_go) begin
            for (int k = HIST_DEPTH - 1; k > 0; k--) begin
                r_xh[k] <= r_xh[k-1];
                r_yh[k] <= r_yh[k-1];
            end
            r_xh[0] <= r_x;
            r_yh[0] <= fin_y;
        end
    end

    // ---------------------------------------------------------------- MAC
    logic signed [COEF_W-1:0]       mac_coef;
    logic signed [SAMPLE_WIDTH-1:0] mac_opnd;
    logic signed [PROD_W-1:0]       r_prod;
    logic                           r_prod_vld, r_prod_sub;
    logic signed [ACC_W-1:0]        r_acc;
    logic signed [ACC_W-1:0]        prod_ext;

    always_comb begin
        if (r_state == ST_FB) begin
            mac_coef = coef_at(r_fb_lo, r_fb_hi, COEF_IDX_W'(r_tap));
            mac_opnd = r_yh[hidx];
        end else begin
            mac_coef = coef_at(r_ff_lo, r_ff_hi, COEF_IDX_W'(r_tap));
            mac_opnd = (r_tap == '0) ? r_x : r_xh[hidx];
        end
    end

    assign prod_ext = ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        r_prod     <= mac_coef * mac_opnd;
        r_prod_sub <= issue_sub;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_vld <= 1'b0;
        end else begin
            r_prod_vld <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_acc <= '0;
        end else if (r_prod_vld) begin
            r_acc <= r_prod_sub ? (r_acc - prod_ext) : (r_acc + prod_ext);
        end else if (r_state == ST_ROUND) begin
            r_acc <= r_acc + $signed(half);
        end
    end

    // ---------------------------------------------------------------- divide
    logic             r_neg, r_derr;
    logic [ACC_W-1:0] acc_mag;

    assign acc_mag = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);

    assign div_req.start    = div_start;
    assign div_req.dividend = acc_mag;
    assign div_req.divisor  = a0_mag;

    iir_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DSET) begin
            r_neg  <= r_acc[ACC_W-1] ^ a0[COEF_W-1];
            r_derr <= a0_zero;
        end
    end

    // Saturate the signed quotient to the sample width
    always_comb begin
        fin_y    = '0;
        fin_clip = 1'b0;
        if (r_derr) begin
            fin_y = '0;
        end else if (!r_neg) begin
            if (div_rsp.quotient > Q_POS_LIMIT) begin
                fin_y    = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
                fin_clip = 1'b1;
            end else begin
                fin_y = div_rsp.quotient[SAMPLE_WIDTH-1:0];
            end
        end else begin
            if (div_rsp.quotient > Q_NEG_LIMIT) begin
                fin_y    = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};
                fin_clip = 1'b1;
            end else begin
                fin_y = -div_rsp.quotient[SAMPLE_WIDTH-1:0];
            end
        end
    end

    // ---------------------------------------------------------------- output register
    logic signed [SAMPLE_WIDTH-1:0] r_y;
    logic                           r_clip, r_derr_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fin_go) begin
            r_out_vld <= 1'b1;
        end else if (out_acc) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_y        <= fin_y;
            r_clip     <= fin_clip;
            r_derr_out <= r_derr;
        end
    end

    assign o_filtered     = 16'(r_y);
    assign o_clipped      = r_clip;
    assign o_divide_error = r_derr_out;

`ifndef SYNTHESIS
    // An accepted item keeps the block busy on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("block not busy after accepting an item");

    // The divider finishes only while the sequencer waits for it
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide state");

    // A finished item always lands in the output register
    a_fin_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fin_go |=> (o_out_valid && (r_state == ST_IDLE)))
        else $error("finished item not presented");

    // A divide error gives a zero, unclipped result
    a_derr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_divide_error) |-> ((o_filtered == '0) && !o_clipped))
        else $error("divide error with nonzero or clipped result");
`endif

endmodule

FILE: hdl/iir_divider.sv
// Unsigned restoring divider, one quotient bit per cycle.
module iir_divider import iir_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [COEF_W-1:0]   r_rem;
    logic [ACC_W-1:0]    r_quo;
    logic [COEF_W-1:0]   r_den;
    logic [DIVCNT_W-1:0] r_cnt;
    logic                r_busy;

    logic [COEF_W:0]   shifted;
    logic [COEF_W+1:0] diff;

    assign shifted = {r_rem, r_quo[ACC_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIVCNT_W'(ACC_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - DIVCNT_W'(1);
            if (r_cnt == DIVCNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            // keep the trial difference when it did not go negative
            if (!diff[COEF_W+1]) begin
                r_rem <= diff[COEF_W-1:0];
                r_quo <= {r_quo[ACC_W-2:0], 1'b1};
            end else begin
                r_rem <= shifted[COEF_W-1:0];
                r_quo <= {r_quo[ACC_W-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.done     = r_busy && (r_cnt == DIVCNT_W'(1));
    assign o_rsp.quotient = r_quo;

endmodule

FILE: test/tb_top.sv
// Self-checking testbench for the integer direct-form I IIR filter.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import iir_pkg::*;

    // Saturation bounds of one output sample
    localparam longint Y_MAX = (longint'(1) << (SAMPLE_WIDTH - 1)) - 1;
    localparam longint Y_MIN = -Y_MAX - 1;

    // Register indexes the block does not decode
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    // Hold-off length for the output-side pressure test, in cycles
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        logic signed [15:0] filtered;
        logic               clipped;
        logic               divide_error;
    } t_y_item;

    typedef enum logic {ROW_REG, ROW_SAMPLE} t_row_kind;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_W-1:0]      data;
        logic signed [15:0]    x;
        logic                  first;
        logic                  typed;
        t_y_item               want;
    } t_dir_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic signed [15:0]    i_sample;
    logic                  i_first;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic signed [15:0]    o_filtered;
    logic                  o_clipped;
    logic                  o_divide_error;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_W-1:0]      i_cfg_data;

    // Shadow copy of the configuration, at reset values
    logic [CFG_W-1:0]      ff_lo = 64'd1;
    logic [CFG_W-1:0]      ff_hi = 64'd0;
    logic [CFG_W-1:0]      fb_lo = 64'd1;
    logic [CFG_W-1:0]      fb_hi = 64'd0;
    logic [TAPREG_W-1:0]   ff_taps = 4'd1;
    logic [TAPREG_W-1:0]   fb_taps = 4'd1;

    // Filter memory of the predictor: x[n-1] and y[n-1] first
    logic signed [15:0]    x_hist [HIST_DEPTH];
    logic signed [15:0]    y_hist [HIST_DEPTH];

    t_y_item               pending_y [$];
    t_dir_row              dir_rows [$];
    t_y_item               head_y;

    int                    sender_idle_pct = 0;
    int                    recv_stall_pct  = 0;
    int                    hold_left       = 0;
    int                    err_count       = 0;
    int                    n_samples       = 0;
    int                    n_results       = 0;
    int                    n_writes        = 0;

    integer_iir_filter_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_sample       (i_sample),
        .i_first        (i_first),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_filtered     (o_filtered),
        .o_clipped      (o_clipped),
        .o_divide_error (o_divide_error),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Stop a hung run
    initial begin
        #4_000_000;
        $display("tb_top: errors");
        $finish;
    end

    // Signed 16-bit coefficient k of a low/high register pair
    function automatic logic signed [15:0] tap_coef(input logic [CFG_W-1:0] lo,
                                                    input logic [CFG_W-1:0] hi,
                                                    input int k);
        logic [CFG_W-1:0] w;
        w = (k < COEF_PER_REG) ? lo : hi;
        return $signed(w[COEF_W * (k % COEF_PER_REG) +: COEF_W]);
    endfunction

    // Run one sample through the filter memory and return the output item
    function automatic t_y_item filter_step(input logic signed [15:0] x, input logic first);
        longint  acc;
        longint  a0;
        longint  q;
        longint  xv;
        int      nb;
        int      na;
        t_y_item r;
        acc = 0;
        r   = '0;
        nb  = (ff_taps > MAX_TAPS) ? MAX_TAPS : int'(ff_taps);
        na  = (fb_taps > MAX_TAPS) ? MAX_TAPS : int'(fb_taps);
        if (first) begin
            for (int j = 0; j < HIST_DEPTH; j++) begin
                x_hist[j] = '0;
                y_hist[j] = '0;
            end
        end
        for (int j = 0; j < nb; j++) begin
            if (j == 0) begin
                xv = longint'(x);
            end else begin
                xv = longint'(x_hist[j-1]);
            end
            acc += longint'(tap_coef(ff_lo, ff_hi, j)) * xv;
        end
        // a zero feedback count behaves as one: no terms past a0
        for (int j = 1; j < na; j++) begin
            acc -= longint'(tap_coef(fb_lo, fb_hi, j)) * longint'(y_hist[j-1]);
        end
        a0 = longint'(tap_coef(fb_lo, fb_hi, 0));
        if (a0 == 0) begin
            r.divide_error = 1'b1;
        end else begin
            // both divisions truncate toward zero
            q = (acc + a0 / 2) / a0;
            if (q > Y_MAX) begin
                q = Y_MAX;
                r.clipped = 1'b1;
            end else if (q < Y_MIN) begin
                q = Y_MIN;
                r.clipped = 1'b1;
            end
            r.filtered = 16'(q);
        end
        for (int j = HIST_DEPTH - 1; j > 0; j--) begin
            x_hist[j] = x_hist[j-1];
            y_hist[j] = y_hist[j-1];
        end
        x_hist[0] = x;
        y_hist[0] = r.filtered;
        return r;
    endfunction

    // Coefficient of a given flavor: wide random, small, or an extreme
    function automatic logic [15:0] pick_coef(input int style);
        logic [15:0] c;
        case (style)
            0: c = 16'($urandom);
            1: c = 16'($urandom_range(0, 16) - 8);
            default: begin
                case ($urandom_range(0, 4))
                    0:       c = 16'h7fff;
                    1:       c = 16'h8000;
                    2:       c = 16'h0000;
                    3:       c = 16'hffff;
                    default: c = 16'h0001;
                endcase
            end
        endcase
        return c;
    endfunction

    // Tap-count register word: random upper bits, count biased to the extremes
    function automatic logic [CFG_W-1:0] pick_taps();
        logic [CFG_W-1:0] d;
        d = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0:       d[TAPREG_W-1:0] = 4'd0;
            1:       d[TAPREG_W-1:0] = 4'd1;
            2:       d[TAPREG_W-1:0] = 4'd8;
            3:       d[TAPREG_W-1:0] = 4'd15;
            default: d[TAPREG_W-1:0] = 4'($urandom_range(0, 15));
        endcase
        return d;
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_W-1:0] data);
        t_dir_row r;
        r      = '0;
        r.kind = ROW_REG;
        r.idx  = idx;
        r.data = data;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_smp(input logic signed [15:0] x, input logic first);
        t_dir_row r;
        r       = '0;
        r.kind  = ROW_SAMPLE;
        r.x     = x;
        r.first = first;
        dir_rows.push_back(r);
    endfunction

    function automatic void add_smp_exp(input logic signed [15:0] x, input logic first,
                                        input logic signed [15:0] y, input logic clip,
                                        input logic dz);
        t_dir_row r;
        r       = '0;
        r.kind  = ROW_SAMPLE;
        r.x     = x;
        r.first = first;
        r.typed = 1'b1;
        r.want  = '{filtered: y, clipped: clip, divide_error: dz};
        dir_rows.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        $display("mismatch at %0t ns: %s got %0d, expected %0d", $time, what, got, want);
    endtask

    // Offer one sample item and hold it until accepted; log its expected result
    task automatic send_sample(input logic signed [15:0] x, input logic f,
                               input logic typed, input t_y_item want);
        t_y_item got;
        // idle gap decided before valid rises, never from the stall
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            i_in_valid = 1'b0;
            i_sample   = 16'($urandom);
            i_first    = 1'($urandom);
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_sample   = x;
        i_first    = f;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        got = filter_step(x, f);
        pending_y.push_back(typed ? want : got);
        n_samples++;
        @(negedge i_clk);
    endtask

    // Write one register and mirror it in the shadow copy
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_FF_LO:   ff_lo   = data;
            CFG_FF_HI:   ff_hi   = data;
            CFG_FB_LO:   fb_lo   = data;
            CFG_FB_HI:   fb_hi   = data;
            CFG_FF_TAPS: ff_taps = data[TAPREG_W-1:0];
            CFG_FB_TAPS: fb_taps = data[TAPREG_W-1:0];
            default: ;
        endcase
        n_writes++;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Drop valid and wait until every expected result has been taken
    task automatic wait_for_results();
        i_in_valid = 1'b0;
        while (pending_y.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Output side: stall at random, or hold off for a counted stretch
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall = 1'b1;
            hold_left   = hold_left - 1;
        end else begin
            i_out_stall = ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Compare every accepted result with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            n_results++;
            if (pending_y.size() == 0) begin
                report_mismatch("result with nothing pending, filtered", int'(o_filtered), 0);
            end else begin
                head_y = pending_y.pop_front();
                if (o_filtered !== head_y.filtered) begin
                    report_mismatch("filtered", int'(o_filtered), int'(head_y.filtered));
                end
                if (o_clipped !== head_y.clipped) begin
                    report_mismatch("clipped", int'(o_clipped), int'(head_y.clipped));
                end
                if (o_divide_error !== head_y.divide_error) begin
                    report_mismatch("divide_error", int'(o_divide_error),
                                    int'(head_y.divide_error));
                end
            end
        end
    end

    initial begin
        int                  run_len;
        int                  n_done;
        int                  fb_style;
        int                  ff_style;
        logic                f;
        logic signed [15:0]  x;
        logic [15:0]         a0w;
        t_y_item             none;

        none        = '0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_sample    = '0;
        i_first     = 1'b0;
        i_out_stall = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        for (int j = 0; j < HIST_DEPTH; j++) begin
            x_hist[j] = '0;
            y_hist[j] = '0;
        end
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part. Reset settings pass samples straight through.
        add_smp_exp(32767, 1'b1, 32767, 1'b0, 1'b0);
        add_smp_exp(-32768, 1'b0, -32768, 1'b0, 1'b0);
        add_smp_exp(0, 1'b0, 0, 1'b0, 1'b0);
        add_smp_exp(-1, 1'b0, -1, 1'b0, 1'b0);
        // zero divisor: output 0 with the error flag
        add_cfg(CFG_FB_LO, 64'h0);
        add_smp_exp(1234, 1'b0, 0, 1'b0, 1'b1);
        add_smp_exp(-32768, 1'b1, 0, 1'b0, 1'b1);
        // largest products saturate both ways
        add_cfg(CFG_FB_LO, 64'h1);
        add_cfg(CFG_FF_LO, 64'h7fff);
        add_smp_exp(32767, 1'b1, 32767, 1'b1, 1'b0);
        add_smp_exp(-32768, 1'b0, -32768, 1'b1, 1'b0);
        add_cfg(CFG_FF_LO, 64'h8000);
        add_smp_exp(-32768, 1'b0, 32767, 1'b1, 1'b0);
        // writes to undecoded indexes leave the settings alone
        add_cfg(CFG_SPARE_LO, '1);
        add_cfg(CFG_SPARE_HI, '1);
        add_smp_exp(5, 1'b0, -32768, 1'b1, 1'b0);
        // all taps, a feed-forward count past the maximum
        add_cfg(CFG_FF_LO, 64'h0003_fffe_0002_0001);
        add_cfg(CFG_FF_HI, 64'h8000_7fff_ffff_0004);
        add_cfg(CFG_FB_LO, 64'h0001_ffff_0002_0004);
        add_cfg(CFG_FB_HI, 64'h7fff_8000_0000_0001);
        add_cfg(CFG_FF_TAPS, 64'hf);
        add_cfg(CFG_FB_TAPS, 64'h8);
        add_smp(100, 1'b1);
        add_smp(-200, 1'b0);
        add_smp(32767, 1'b0);
        add_smp(-32768, 1'b0);
        add_smp(7, 1'b0);
        add_smp(0, 1'b0);
        // both counts zero: the sum starts at zero, a0 still divides
        add_cfg(CFG_FF_TAPS, 64'h0);
        add_cfg(CFG_FB_TAPS, 64'h0);
        add_smp(1000, 1'b0);
        add_smp(-5, 1'b0);
        // negative divisor, rounding toward zero
        add_cfg(CFG_FF_LO, 64'h0000_0000_0001_0001);
        add_cfg(CFG_FB_LO, 64'h0000_0000_0001_fffd);
        add_cfg(CFG_FF_TAPS, 64'h2);
        add_cfg(CFG_FB_TAPS, 64'h2);
        add_smp(10, 1'b1);
        add_smp(-10, 1'b0);
        add_smp(11, 1'b0);
        // divisor at its positive and negative extremes
        add_cfg(CFG_FF_LO, 64'h0000_0000_7fff_7fff);
        add_cfg(CFG_FB_LO, 64'h0000_0000_0000_7fff);
        add_smp(32767, 1'b1);
        add_smp(-32768, 1'b0);
        add_cfg(CFG_FB_LO, 64'h0000_0000_0000_8000);
        add_smp(-32768, 1'b1);
        add_smp(32767, 1'b0);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_REG) begin
                wait_for_results();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end else begin
                send_sample(dir_rows[i].x, dir_rows[i].first, dir_rows[i].typed,
                            dir_rows[i].want);
            end
        end

        // Random part: four idling stages, three settings each
        for (int stage = 0; stage < 4; stage++) begin
            wait_for_results();
            @(posedge i_clk);
            case (stage)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 45; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 45; end
                default: begin sender_idle_pct = 34; recv_stall_pct = 34; end
            endcase
            @(negedge i_clk);
            for (int seg = 0; seg < 3; seg++) begin
                wait_for_results();
                // mostly small coefficients so the recursion does not pin at the rails
                ff_style = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 2)) : 1;
                fb_style = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 2)) : 1;
                case ($urandom_range(0, 9))
                    0:       a0w = 16'h0000;
                    1:       a0w = 16'h7fff;
                    2:       a0w = 16'h8000;
                    3:       a0w = 16'h0001;
                    4:       a0w = 16'hffff;
                    5:       a0w = -16'($urandom_range(2, 300));
                    default: a0w = 16'($urandom_range(2, 300));
                endcase
                write_reg(CFG_FF_LO, {pick_coef(ff_style), pick_coef(ff_style),
                                      pick_coef(ff_style), pick_coef(ff_style)});
                write_reg(CFG_FF_HI, {pick_coef(ff_style), pick_coef(ff_style),
                                      pick_coef(ff_style), pick_coef(ff_style)});
                write_reg(CFG_FB_LO, {pick_coef(fb_style), pick_coef(fb_style),
                                      pick_coef(fb_style), a0w});
                write_reg(CFG_FB_HI, {pick_coef(fb_style), pick_coef(fb_style),
                                      pick_coef(fb_style), pick_coef(fb_style)});
                write_reg(CFG_FF_TAPS, pick_taps());
                write_reg(CFG_FB_TAPS, pick_taps());
                if ($urandom_range(0, 2) == 0) begin
                    write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                              {$urandom, $urandom});
                end

                n_done = 0;
                while (n_done < 50) begin
                    run_len = $urandom_range(1, 24);
                    for (int i = 0; i < run_len && n_done < 50; i++) begin
                        // a run opens with first set; flip it now and then
                        f = (i == 0);
                        if ($urandom_range(0, 19) == 0) f = ~f;
                        if ($urandom_range(0, 4) == 0) begin
                            case ($urandom_range(0, 4))
                                0:       x = 16'sh7fff;
                                1:       x = 16'sh8000;
                                2:       x = 16'sh0000;
                                3:       x = -16'sd1;
                                default: x = 16'sd1;
                            endcase
                        end else begin
                            x = 16'($urandom);
                        end
                        if (stage == 0 && seg == 1 && n_done == 10) begin
                            // hold off the output so the block fills and stalls its input
                            i_in_valid = 1'b0;
                            @(posedge i_clk);
                            hold_left = LONG_HOLD;
                            @(negedge i_clk);
                        end
                        if (stage == 1 && seg == 2 && n_done == 25) begin
                            // pause the sender until the pipeline is empty
                            wait_for_results();
                        end
                        send_sample(x, f, 1'b0, none);
                        n_done++;
                    end
                end
            end
        end

        wait_for_results();
        repeat (96) @(posedge i_clk);
        $display("run covered %0d samples, %0d results, %0d register writes, %0d mismatches",
                 n_samples, n_results, n_writes, err_count);
        $display("stimulus: directed extremes, zero and extreme divisors, tap clamping, ",
                 "ignored indexes, then random runs under four idling stages");
        if (err_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule

FILE: filelist.f
hdl/iir_pkg.sv
hdl/iir_divider.sv
hdl/integer_iir_filter_top.sv
test/tb_top.sv
